// ===== rtl/assert_macros.svh =====
// Shared assertion macros for the line pixel generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/lpg_pkg.sv =====
`default_nettype none
package lpg_pkg;

  localparam int COORD_BITS  = 12;
  localparam int ERR_BITS    = COORD_BITS + 2;
  localparam int COLOR_BITS  = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_FIELD_BITS  = 4 * COORD_BITS;
  localparam int IN_DATA_W      = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
  localparam int OUT_DATA_W     = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  // Decoded command as it sits in the queue; setup terms only matter on start.
  typedef struct packed {
    cmd_t   cmd;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t dx;
    coord_t dy;
    logic   xb;
    logic   yb;
    err_t   err;
  } op_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== rtl/lpg_front.sv =====
`default_nettype none
module lpg_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [lpg_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [0:0]               in_tuser,
  input  wire lpg_pkg::q_stat_t         q_stat,
  output logic                          q_push,
  output lpg_pkg::op_t                  q_op
);
  import lpg_pkg::*;

  logic   op_valid_r, op_valid_nxt;
  op_t    op_r;
  op_t    op_nxt;
  coord_t x0, y0, x1, y1;
  logic   accept;

  assign x0 = in_tdata[0*COORD_BITS +: COORD_BITS];
  assign y0 = in_tdata[1*COORD_BITS +: COORD_BITS];
  assign x1 = in_tdata[2*COORD_BITS +: COORD_BITS];
  assign y1 = in_tdata[3*COORD_BITS +: COORD_BITS];

  assign q_push    = op_valid_r && !q_stat.full;
  assign in_tready = !op_valid_r || !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign q_op      = op_r;

  // Precompute the line setup so the back end only loads it.
  always_comb begin
    op_nxt.cmd = cmd_t'(in_tuser[0]);
    op_nxt.x0  = x0;
    op_nxt.y0  = y0;
    op_nxt.x1  = x1;
    op_nxt.y1  = y1;
    op_nxt.xb  = !(x0 < x1);
    op_nxt.yb  = !(y0 < y1);
    op_nxt.dx  = (x0 > x1) ? (x0 - x1) : (x1 - x0);
    op_nxt.dy  = (y0 > y1) ? (y0 - y1) : (y1 - y0);
    op_nxt.err = err_t'({2'b00, op_nxt.dx}) - err_t'({2'b00, op_nxt.dy});
  end

  always_comb begin
    op_valid_nxt = op_valid_r;
    if (accept) begin
      op_valid_nxt = 1'b1;
    end else if (q_push) begin
      op_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r <= 1'b0;
    end else begin
      op_valid_r <= op_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lpg_queue.sv =====
`default_nettype none
module lpg_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lpg_pkg::op_t  push_op,
  input  wire logic          pop,
  output lpg_pkg::op_t       head_op,
  output lpg_pkg::q_stat_t   stat
);
  import lpg_pkg::*;

  op_t                  mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign head_op    = mem_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lpg_back.sv =====
`default_nettype none
module lpg_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire lpg_pkg::q_stat_t               q_stat,
  input  wire lpg_pkg::op_t                   q_op,
  output logic                                q_pop,
  input  wire logic                           cfg_wr_en,
  input  wire logic [lpg_pkg::COLOR_BITS-1:0] cfg_wr_data,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [lpg_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast
);
  import lpg_pkg::*;

  localparam int TW = ERR_BITS + 1;

  logic                  busy_r, busy_nxt;
  coord_t                cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  coord_t                end_x_r, end_x_nxt, end_y_r, end_y_nxt;
  coord_t                dx_r, dx_nxt, dy_r, dy_nxt;
  err_t                  err_r, err_nxt;
  logic                  xb_r, xb_nxt, yb_r, yb_nxt;
  logic [COLOR_BITS-1:0] color_r;

  logic                  out_valid_r, out_valid_nxt;
  coord_t                px_r, py_r;
  logic [COLOR_BITS-1:0] pcolor_r;
  logic                  plast_r;

  logic                  out_free, is_start, emit, at_end, move_x, move_y;
  logic signed [TW-1:0]  twice, dx_s, dy_s;

  assign out_free = !out_valid_r || out_tready;
  assign is_start = (q_op.cmd == CMD_START);
  // A step on an idle line is dropped without needing the output slot.
  assign q_pop    = q_stat.valid && (is_start || !busy_r || out_free);
  assign emit     = q_pop && !is_start && busy_r;
  assign at_end   = (cur_x_r == end_x_r) && (cur_y_r == end_y_r);

  assign twice  = {err_r, 1'b0};
  assign dx_s   = {{(TW - COORD_BITS){1'b0}}, dx_r};
  assign dy_s   = {{(TW - COORD_BITS){1'b0}}, dy_r};
  assign move_x = twice > -dy_s;
  assign move_y = twice < dx_s;

  always_comb begin
    busy_nxt  = busy_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    end_x_nxt = end_x_r;
    end_y_nxt = end_y_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    err_nxt   = err_r;
    xb_nxt    = xb_r;
    yb_nxt    = yb_r;
    if (q_pop && is_start) begin
      busy_nxt  = 1'b1;
      cur_x_nxt = q_op.x0;
      cur_y_nxt = q_op.y0;
      end_x_nxt = q_op.x1;
      end_y_nxt = q_op.y1;
      dx_nxt    = q_op.dx;
      dy_nxt    = q_op.dy;
      err_nxt   = q_op.err;
      xb_nxt    = q_op.xb;
      yb_nxt    = q_op.yb;
    end else if (emit) begin
      if (at_end) begin
        busy_nxt = 1'b0;
      end else begin
        err_nxt = err_r - (move_x ? err_t'({2'b00, dy_r}) : '0)
                        + (move_y ? err_t'({2'b00, dx_r}) : '0);
        if (move_x) begin
          cur_x_nxt = xb_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
        end
        if (move_y) begin
          cur_y_nxt = yb_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      end_x_r     <= '0;
      end_y_r     <= '0;
      dx_r        <= '0;
      dy_r        <= '0;
      err_r       <= '0;
      xb_r        <= 1'b0;
      yb_r        <= 1'b0;
      color_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      end_x_r     <= end_x_nxt;
      end_y_r     <= end_y_nxt;
      dx_r        <= dx_nxt;
      dy_r        <= dy_nxt;
      err_r       <= err_nxt;
      xb_r        <= xb_nxt;
      yb_r        <= yb_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      px_r     <= cur_x_r;
      py_r     <= cur_y_r;
      pcolor_r <= color_r;
      plast_r  <= at_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = plast_r;
  assign out_tdata  = OUT_DATA_W'({pcolor_r, py_r, px_r});

endmodule
`default_nettype wire

// ===== rtl/line_pixel_generator_top.sv =====
`default_nettype none
// Bresenham line rasterizer. A start beat (tuser = 0) loads both endpoints and
// yields no pixel; each step beat (tuser = 1) yields the current pixel with the
// color register and advances along the line, tlast marking the end point.
// A step with no line in progress is dropped; a start mid-line restarts.
// One beat is taken per clock cycle while in_tready is high; the step datapath
// (error update and coordinate move) is combinational, so a stream of steps gives
// one pixel per cycle while the output is not stalled. A pixel passes through the
// front setup register, a command queue entry and the output register before it
// shows on out_tvalid, and is held there while the output is stalled. Write color
// only while no beat is in flight.
module line_pixel_generator_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // x_start, y_start, x_end, y_end
  input  wire logic [lpg_pkg::IN_DATA_W-1:0]  in_tdata,
  // command
  input  wire logic [0:0]                     in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // pixel_x, pixel_y, color
  output logic [lpg_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast,
  input  wire logic                           cfg_wr_en,
  input  wire logic [lpg_pkg::COLOR_BITS-1:0] cfg_wr_data
);
  import lpg_pkg::*;

  q_stat_t q_stat;
  op_t     push_op, head_op;
  logic    q_push, q_pop;

  lpg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_op      (push_op)
  );

  lpg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .head_op (head_op),
    .stat    (q_stat)
  );

  lpg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .q_op        (head_op),
    .q_pop       (q_pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
`default_nettype wire

// ===== rtl/lpg_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module lpg_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [lpg_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           out_tlast
);

  // Hold a stalled pixel beat unchanged.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // Leaving reset, the pipeline is empty: input open, no pixel pending.
  `ASSERT_IMPL(a_rst_ready, clk, rst_n, $rose(rst_n), in_tready)
  `ASSERT_IMPL(a_rst_no_pixel, clk, rst_n, $rose(rst_n), !out_tvalid)

endmodule

bind line_pixel_generator_top lpg_checker u_lpg_checker (.*);
`default_nettype wire
